// ===== src/hrd_pkg.sv =====
// Types and constants for the hex record deframer.
// Shared by the configuration bank, the step logic and the top level.
package hrd_pkg;

    // Phase codes, as shown on phase_code
    localparam logic [3:0] PH_WAIT  = 4'd0;
    localparam logic [3:0] PH_LEN   = 4'd1;
    localparam logic [3:0] PH_OFFHI = 4'd2;
    localparam logic [3:0] PH_OFFLO = 4'd3;
    localparam logic [3:0] PH_TYPE  = 4'd4;
    localparam logic [3:0] PH_BASE  = 4'd5;
    localparam logic [3:0] PH_DATA  = 4'd6;
    localparam logic [3:0] PH_CHK   = 4'd7;
    localparam logic [3:0] PH_DONE  = 4'd8;
    localparam logic [3:0] PH_ERROR = 4'd9;

    // Record types
    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;
    localparam logic [7:0] REC_ULBA = 8'h04;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_CODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_APP_CODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_LIMIT   = 2'd2;

    localparam logic [7:0] START_CODE_RST   = 8'h55;
    localparam logic [7:0] RUN_APP_CODE_RST = 8'hAA;
    localparam logic [7:0] WAIT_LIMIT_RST   = 8'hFF;

    // Low byte used to pad a final odd data byte
    localparam logic [7:0] PAD_BYTE = 8'hFF;

    typedef struct packed {
        logic [7:0] start_code;
        logic [7:0] run_app_code;
        logic [7:0] wait_limit;
    } hrd_cfg_t;

    typedef struct packed {
        logic [3:0]  phase;
        logic [7:0]  wait_count;
        logic [7:0]  record_length;
        logic [15:0] offset_address;
        logic [15:0] upper_address;
        logic [7:0]  running_sum;
        logic [7:0]  byte_index;
        logic [7:0]  held_high_byte;
        logic        base_byte_count;
    } hrd_state_t;

    typedef struct packed {
        logic        write_valid;
        logic [31:0] write_address;
        logic [15:0] write_data;
        logic        erase_request;
        logic        line_ok;
        logic        record_error;
        logic        load_done;
        logic [3:0]  phase_code;
    } hrd_result_t;

endpackage

// ===== src/hrd_if.sv =====
// Handshake channels of the hex record deframer: received bytes in, results out.
// Stand-alone; no package needed.
interface hrd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       rx_timeout;

    modport source (output valid, output rx_byte, output rx_timeout, input ready);
    modport sink   (input valid, input rx_byte, input rx_timeout, output ready);
endinterface

interface hrd_out_if;
    logic        valid;
    logic        ready;
    logic        write_valid;
    logic [31:0] write_address;
    logic [15:0] write_data;
    logic        erase_request;
    logic        line_ok;
    logic        record_error;
    logic        load_done;
    logic [3:0]  phase_code;

    modport source (output valid, output write_valid, output write_address,
                    output write_data, output erase_request, output line_ok,
                    output record_error, output load_done, output phase_code,
                    input ready);
    modport sink   (input valid, input write_valid, input write_address,
                    input write_data, input erase_request, input line_ok,
                    input record_error, input load_done, input phase_code,
                    output ready);
endinterface

// ===== src/hrd_cfg_regs.sv =====
// Configuration register bank: start code, application code and wait limit.
// Depends on hrd_pkg.
module hrd_cfg_regs
    import hrd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_wdata,
    output hrd_cfg_t             cfg
);

    hrd_cfg_t cfg_reg;
    hrd_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_CODE:   cfg_next.start_code   = cfg_wdata;
                CFG_RUN_APP_CODE: cfg_next.run_app_code = cfg_wdata;
                CFG_WAIT_LIMIT:   cfg_next.wait_limit   = cfg_wdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_code   <= START_CODE_RST;
            cfg_reg.run_app_code <= RUN_APP_CODE_RST;
            cfg_reg.wait_limit   <= WAIT_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/hrd_step.sv =====
// Per-beat record decoding: next parser state and the result for one byte.
// Purely combinational. Depends on hrd_pkg.
module hrd_step
    import hrd_pkg::*;
(
    input  hrd_cfg_t    cfg,
    input  hrd_state_t  state,
    input  logic [7:0]  rx_byte,
    input  logic        rx_timeout,
    output hrd_state_t  state_next,
    output hrd_result_t result
);

    logic [7:0]  index_inc;
    logic        last_byte;
    logic [7:0]  pair_index;
    logic [31:0] pair_address;
    logic [7:0]  sum_next;

    assign index_inc  = state.byte_index + 8'd1;
    assign last_byte  = (index_inc == state.record_length);
    // a pair always starts at an even index
    assign pair_index = {state.byte_index[7:1], 1'b0};
    assign pair_address = {state.upper_address, 16'h0000}
                        + {16'h0000, state.offset_address}
                        + {24'h000000, pair_index};
    assign sum_next   = state.running_sum + rx_byte;

    always_comb
    begin
        state_next = state;
        result     = '0;

        if (state.phase == PH_WAIT)
        begin
            if (state.wait_count >= cfg.wait_limit)
            begin
                state_next.phase = PH_DONE;
                result.load_done = 1'b1;
            end
            else if (rx_timeout)
            begin
                state_next.wait_count = state.wait_count + 8'd1;
            end
            else if (rx_byte == cfg.start_code)
            begin
                result.erase_request        = 1'b1;
                state_next.record_length    = '0;
                state_next.offset_address   = '0;
                state_next.running_sum      = '0;
                state_next.wait_count       = '0;
                state_next.byte_index       = '0;
                state_next.phase            = PH_LEN;
            end
            else if (rx_byte == cfg.run_app_code)
            begin
                state_next.phase = PH_DONE;
                result.load_done = 1'b1;
            end
            else
            begin
                state_next.wait_count = state.wait_count + 8'd1;
            end
        end
        else if (!rx_timeout)
        begin
            case (state.phase)
                PH_LEN:
                begin
                    state_next.record_length = rx_byte;
                    state_next.running_sum   = sum_next;
                    state_next.phase         = PH_OFFHI;
                end
                PH_OFFHI:
                begin
                    state_next.offset_address = {rx_byte, 8'h00};
                    state_next.running_sum    = sum_next;
                    state_next.phase          = PH_OFFLO;
                end
                PH_OFFLO:
                begin
                    state_next.offset_address = {state.offset_address[15:8], rx_byte};
                    state_next.running_sum    = sum_next;
                    state_next.phase          = PH_TYPE;
                end
                PH_TYPE:
                begin
                    state_next.running_sum = sum_next;
                    if (rx_byte == REC_ULBA)
                    begin
                        state_next.base_byte_count = 1'b0;
                        state_next.phase           = PH_BASE;
                    end
                    else if (rx_byte == REC_DATA)
                    begin
                        state_next.byte_index = '0;
                        state_next.phase = (state.record_length == 8'd0) ? PH_CHK : PH_DATA;
                    end
                    else if (rx_byte == REC_EOF)
                    begin
                        state_next.phase = PH_DONE;
                        result.load_done = 1'b1;
                    end
                    else
                    begin
                        state_next.phase    = PH_ERROR;
                        result.record_error = 1'b1;
                    end
                end
                PH_BASE:
                begin
                    state_next.running_sum = sum_next;
                    if (!state.base_byte_count)
                    begin
                        state_next.upper_address   = {rx_byte, 8'h00};
                        state_next.base_byte_count = 1'b1;
                    end
                    else
                    begin
                        state_next.upper_address   = {state.upper_address[15:8], rx_byte};
                        state_next.base_byte_count = 1'b0;
                        state_next.phase           = PH_CHK;
                    end
                end
                PH_DATA:
                begin
                    state_next.running_sum = sum_next;
                    state_next.byte_index  = index_inc;
                    if (!state.byte_index[0])
                    begin
                        // hold the high byte; pad with 0xFF if it is the last one
                        state_next.held_high_byte = rx_byte;
                        if (last_byte)
                        begin
                            result.write_valid   = 1'b1;
                            result.write_address = pair_address;
                            result.write_data    = {rx_byte, PAD_BYTE};
                        end
                    end
                    else
                    begin
                        result.write_valid   = 1'b1;
                        result.write_address = pair_address;
                        result.write_data    = {state.held_high_byte, rx_byte};
                    end
                    if (last_byte)
                    begin
                        state_next.phase = PH_CHK;
                    end
                end
                PH_CHK:
                begin
                    if (rx_byte == (8'd0 - state.running_sum))
                    begin
                        result.line_ok            = 1'b1;
                        state_next.record_length  = '0;
                        state_next.offset_address = '0;
                        state_next.running_sum    = '0;
                        state_next.wait_count     = '0;
                        state_next.byte_index     = '0;
                        state_next.phase          = PH_LEN;
                    end
                    else
                    begin
                        state_next.phase    = PH_ERROR;
                        result.record_error = 1'b1;
                    end
                end
                default:
                begin
                    // done, error and unused codes: drop the beat
                    state_next = state;
                end
            endcase
        end

        result.phase_code = state_next.phase;
    end

endmodule

// ===== src/hex_record_deframer_core.sv =====
// Top level of the hex record deframer: input register, step logic, result register.
// Depends on hrd_pkg, hrd_if, hrd_cfg_regs and hrd_step.
//
//   port      dir   kind        beat contents
//   in_ch     in    valid/ready rx_byte, rx_timeout
//   out_ch    out   valid/ready write_valid/address/data, erase, line_ok, error, done, phase
//   cfg_*     in    write only  cfg_index selects start code, app code or wait limit
//
// One byte per cycle sustained while out_ch.ready stays high; each beat passes through
// the input register, then the step logic into the result register.
// Reset clears the parser to waiting for the start code and loads the default codes.
// A stall on out_ch holds the result register; the input register takes one more
// beat only if it is empty, and in_ch.ready drops while it holds one.
module hex_record_deframer_core
    import hrd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    hrd_in_if.sink               in_ch,
    hrd_out_if.source            out_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_wdata
);

    hrd_cfg_t    cfg;
    hrd_state_t  state_reg;
    hrd_state_t  state_next;
    hrd_result_t step_result;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_timeout_reg;
    logic        out_valid_reg;
    hrd_result_t out_reg;
    logic        fire;

    hrd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    hrd_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .rx_byte    (in_byte_reg),
        .rx_timeout (in_timeout_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    // advance a beat when the result register is free or being emptied
    assign fire        = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                in_valid_reg <= in_ch.valid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_byte_reg    <= in_ch.rx_byte;
            in_timeout_reg <= in_ch.rx_timeout;
        end
        if (fire)
        begin
            out_reg <= step_result;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.write_valid   = out_reg.write_valid;
    assign out_ch.write_address = out_reg.write_address;
    assign out_ch.write_data    = out_reg.write_data;
    assign out_ch.erase_request = out_reg.erase_request;
    assign out_ch.line_ok       = out_reg.line_ok;
    assign out_ch.record_error  = out_reg.record_error;
    assign out_ch.load_done     = out_reg.load_done;
    assign out_ch.phase_code    = out_reg.phase_code;

endmodule
